// ===== sv/tbcc_pkg.sv =====
package tbcc_pkg;

   localparam int COORD_W = 16;
   localparam int SCREEN_W = 17;
   localparam int RGB_W = 24;
   localparam int CODE_W = 8;
   localparam int OPCODE_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [OPCODE_W-1:0] OP_MONO_COLOR = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_MONO_CHAR = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_COLOR_KEY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_LEFT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_TOP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_RIGHT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_BOTTOM = 2'd3;

   localparam logic [RGB_W-1:0] RGB_BLACK = 24'h000000;
   localparam logic [CODE_W-1:0] CODE_ONE = 8'h31;
   localparam logic [CODE_W-1:0] CODE_ZERO = 8'h30;

   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] bottom;
   } clip_bounds_type;

   typedef struct packed {
      logic             draw;
      logic [RGB_W-1:0] color;
   } shade_result_type;

endpackage

// ===== sv/tbcc_shade.sv =====
module tbcc_shade (
   input  logic [tbcc_pkg::OPCODE_W-1:0] opcode,
   input  logic [tbcc_pkg::RGB_W-1:0]    pixel_color,
   input  logic [tbcc_pkg::CODE_W-1:0]   pixel_code,
   input  logic [tbcc_pkg::RGB_W-1:0]    fore_color,
   input  logic [tbcc_pkg::RGB_W-1:0]    back_color,
   input  logic                          transparent_mode,
   input  logic [tbcc_pkg::RGB_W-1:0]    key_color,
   output tbcc_pkg::shade_result_type    shade
);
   import tbcc_pkg::*;

   logic color_fg;
   logic code_fg;

   assign color_fg = (pixel_color == RGB_BLACK);
   assign code_fg = (pixel_code >= CODE_ONE);

   always_comb begin
      shade.draw = 1'b0;
      shade.color = '0;
      case (opcode)
         OP_MONO_COLOR: begin
            shade.color = color_fg ? fore_color : back_color;
            shade.draw = !transparent_mode || color_fg;
         end
         OP_MONO_CHAR: begin
            // only the code '0' is skipped; lower codes still paint background
            shade.color = code_fg ? fore_color : back_color;
            shade.draw = !transparent_mode || (pixel_code != CODE_ZERO);
         end
         OP_COLOR_KEY: begin
            shade.color = pixel_color;
            shade.draw = !transparent_mode || (pixel_color != key_color);
         end
         default: begin
            shade.draw = 1'b0;
            shade.color = '0;
         end
      endcase
   end

endmodule

// ===== sv/tbcc_clip.sv =====
module tbcc_clip (
   input  tbcc_pkg::clip_bounds_type             bounds,
   input  logic signed [tbcc_pkg::SCREEN_W-1:0] screen_x,
   input  logic signed [tbcc_pkg::SCREEN_W-1:0] screen_y,
   input  logic                                  ignore_clip,
   output logic                                  hidden
);
   import tbcc_pkg::*;

   logic signed [SCREEN_W-1:0] left_x;
   logic signed [SCREEN_W-1:0] top_x;
   logic signed [SCREEN_W-1:0] right_x;
   logic signed [SCREEN_W-1:0] bottom_x;
   logic                       active;
   logic                       in_box;

   assign left_x = {bounds.left[COORD_W-1], bounds.left};
   assign top_x = {bounds.top[COORD_W-1], bounds.top};
   assign right_x = {bounds.right[COORD_W-1], bounds.right};
   assign bottom_x = {bounds.bottom[COORD_W-1], bounds.bottom};

   // an all-zero rectangle turns clipping off
   assign active = |{bounds.left, bounds.top, bounds.right, bounds.bottom};
   assign in_box = (screen_x >= left_x) && (screen_x <= right_x) &&
                   (screen_y >= top_x) && (screen_y <= bottom_x);
   assign hidden = active && !ignore_clip && !in_box;

endmodule

// ===== sv/tile_blitter_clip_colorkey_core.sv =====
// Tile blitter with clip rectangle and colour key. One tile pixel is taken per
// word on the req_ channel, in raster order, and one write decision leaves on
// the rsp_ channel for each, with screen coordinate, colour and a tile_done flag
// on the last pixel of the tile. The block sustains one pixel per clock while
// rsp_ready is high: a word passes an input register, then a result register
// whose output is the response, and the pixel counter is stepped as each word is
// accepted. Set first_pixel on the first pixel of every tile; otherwise the
// position wraps after TILE_PIXELS pixels. Write the clip bounds through csr_
// only while no pixels are in flight; all four at zero disables clipping.
module tile_blitter_clip_colorkey_core #(
   parameter int TILE_SIDE = 8,
   parameter int TILE_PIXELS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [tbcc_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic                                  req_first_pixel,
   input  logic [tbcc_pkg::RGB_W-1:0]            req_pixel_color,
   input  logic [tbcc_pkg::CODE_W-1:0]           req_pixel_code,
   input  logic [tbcc_pkg::RGB_W-1:0]            req_fore_color,
   input  logic [tbcc_pkg::RGB_W-1:0]            req_back_color,
   input  logic                                  req_transparent_mode,
   input  logic [tbcc_pkg::RGB_W-1:0]            req_key_color,
   input  logic signed [tbcc_pkg::COORD_W-1:0]   req_origin_x,
   input  logic signed [tbcc_pkg::COORD_W-1:0]   req_origin_y,
   input  logic                                  req_ignore_clip,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_write_enable,
   output logic signed [tbcc_pkg::SCREEN_W-1:0]  rsp_screen_x,
   output logic signed [tbcc_pkg::SCREEN_W-1:0]  rsp_screen_y,
   output logic [tbcc_pkg::RGB_W-1:0]            rsp_out_color,
   output logic                                  rsp_tile_done,
   input  logic                                  csr_write_enable,
   input  logic [tbcc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tbcc_pkg::COORD_W-1:0]          csr_wdata
);
   import tbcc_pkg::*;

   localparam int POS_W = (TILE_PIXELS > 1) ? $clog2(TILE_PIXELS) : 1;
   localparam int COL_W = $clog2(TILE_SIDE);
   localparam int ROW_MAX = (TILE_PIXELS - 1) / TILE_SIDE;
   localparam int ROW_W = (ROW_MAX > 0) ? $clog2(ROW_MAX + 1) : 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(TILE_PIXELS - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(TILE_SIDE - 1);

   // clip registers
   clip_bounds_type clip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CLIP_LEFT:   clip_ff.left <= csr_wdata;
            CSR_CLIP_TOP:    clip_ff.top <= csr_wdata;
            CSR_CLIP_RIGHT:  clip_ff.right <= csr_wdata;
            CSR_CLIP_BOTTOM: clip_ff.bottom <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // pixel position, kept as linear index plus column and row
   logic [POS_W-1:0] pos_ff, pos_in, pos_cur;
   logic [COL_W-1:0] col_ff, col_in, col_cur;
   logic [ROW_W-1:0] row_ff, row_in, row_cur;
   logic             done_cur;
   logic             req_accept;

   assign pos_cur = req_first_pixel ? '0 : pos_ff;
   assign col_cur = req_first_pixel ? '0 : col_ff;
   assign row_cur = req_first_pixel ? '0 : row_ff;
   assign done_cur = (pos_cur == POS_LAST);

   always_comb begin
      pos_in = pos_cur + 1'b1;
      col_in = col_cur + 1'b1;
      row_in = row_cur;
      if (col_cur == COL_LAST) begin
         col_in = '0;
         row_in = row_cur + 1'b1;
      end
      if (done_cur) begin
         pos_in = '0;
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         pos_ff <= pos_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // input register
   logic                       s1_valid_ff;
   logic [OPCODE_W-1:0]        s1_opcode_ff;
   logic [RGB_W-1:0]           s1_pixel_color_ff;
   logic [CODE_W-1:0]          s1_pixel_code_ff;
   logic [RGB_W-1:0]           s1_fore_color_ff;
   logic [RGB_W-1:0]           s1_back_color_ff;
   logic                       s1_transparent_ff;
   logic [RGB_W-1:0]           s1_key_color_ff;
   logic signed [SCREEN_W-1:0] s1_screen_x_ff;
   logic signed [SCREEN_W-1:0] s1_screen_y_ff;
   logic                       s1_ignore_clip_ff;
   logic                       s1_done_ff;
   logic signed [SCREEN_W-1:0] screen_x_in;
   logic signed [SCREEN_W-1:0] screen_y_in;
   logic                       s1_advance;
   logic                       s2_ready;

   assign screen_x_in = {req_origin_x[COORD_W-1], req_origin_x} +
                        SCREEN_W'({1'b0, col_cur});
   assign screen_y_in = {req_origin_y[COORD_W-1], req_origin_y} +
                        SCREEN_W'({1'b0, row_cur});

   assign s2_ready = !rsp_valid || rsp_ready;
   assign s1_advance = s1_valid_ff && s2_ready;
   assign req_ready = !s1_valid_ff || s2_ready;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_opcode_ff <= req_opcode;
         s1_pixel_color_ff <= req_pixel_color;
         s1_pixel_code_ff <= req_pixel_code;
         s1_fore_color_ff <= req_fore_color;
         s1_back_color_ff <= req_back_color;
         s1_transparent_ff <= req_transparent_mode;
         s1_key_color_ff <= req_key_color;
         s1_screen_x_ff <= screen_x_in;
         s1_screen_y_ff <= screen_y_in;
         s1_ignore_clip_ff <= req_ignore_clip;
         s1_done_ff <= done_cur;
      end
   end

   // pixel decision
   shade_result_type shade;
   logic             hidden;

   tbcc_shade u_shade (
      .opcode           (s1_opcode_ff),
      .pixel_color      (s1_pixel_color_ff),
      .pixel_code       (s1_pixel_code_ff),
      .fore_color       (s1_fore_color_ff),
      .back_color       (s1_back_color_ff),
      .transparent_mode (s1_transparent_ff),
      .key_color        (s1_key_color_ff),
      .shade            (shade)
   );

   tbcc_clip u_clip (
      .bounds      (clip_ff),
      .screen_x    (s1_screen_x_ff),
      .screen_y    (s1_screen_y_ff),
      .ignore_clip (s1_ignore_clip_ff),
      .hidden      (hidden)
   );

   // result register
   logic                       rsp_valid_ff;
   logic                       rsp_we_ff;
   logic signed [SCREEN_W-1:0] rsp_x_ff;
   logic signed [SCREEN_W-1:0] rsp_y_ff;
   logic [RGB_W-1:0]           rsp_color_ff;
   logic                       rsp_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_we_ff <= shade.draw && !hidden;
         rsp_x_ff <= s1_screen_x_ff;
         rsp_y_ff <= s1_screen_y_ff;
         rsp_color_ff <= shade.color;
         rsp_done_ff <= s1_done_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_write_enable = rsp_we_ff;
   assign rsp_screen_x = rsp_x_ff;
   assign rsp_screen_y = rsp_y_ff;
   assign rsp_out_color = rsp_color_ff;
   assign rsp_tile_done = rsp_done_ff;

endmodule

// ===== sv/tbcc_checker.sv =====
module tbcc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_write_enable,
   input logic signed [tbcc_pkg::SCREEN_W-1:0] rsp_screen_x,
   input logic signed [tbcc_pkg::SCREEN_W-1:0] rsp_screen_y,
   input logic [tbcc_pkg::RGB_W-1:0]           rsp_out_color,
   input logic                                 rsp_tile_done
);
   import tbcc_pkg::*;

   // a stalled response word holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_enable) &&
         $stable(rsp_screen_x) && $stable(rsp_screen_y) &&
         $stable(rsp_out_color) && $stable(rsp_tile_done))
      else $error("stalled response word changed");

   // a fresh response comes from a word that passed the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching request");

   // input backs up only when the result register is full and stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while output can drain");

   // nothing leaves straight after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind tile_blitter_clip_colorkey_core tbcc_checker u_tbcc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_write_enable (rsp_write_enable),
   .rsp_screen_x     (rsp_screen_x),
   .rsp_screen_y     (rsp_screen_y),
   .rsp_out_color    (rsp_out_color),
   .rsp_tile_done    (rsp_tile_done)
);
